// ----- rtl/core/btb_pkg.sv -----
// Branch target buffer package: sizes, command codes, request and entry types.
package btb_pkg;

    localparam int INDEX_BITS  = 10;
    localparam int OFFSET_BITS = 6;

    localparam int NUM_ENTRIES = 1 << INDEX_BITS;
    localparam int TAG_SHIFT   = OFFSET_BITS + INDEX_BITS;
    localparam int TAG_W       = 64 - TAG_SHIFT;
    localparam int OFF_W       = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
    localparam logic [63:0] OFF_MASK = (64'd1 << OFFSET_BITS) - 64'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_PREDICT  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [1:0] CMD_TRAIN_TGT = 2'd2;
    localparam logic [1:0] CMD_TRAIN_CNT = 2'd3;

    localparam logic [1:0] CNT_RESET_TAKEN = 2'd2;
    localparam logic [1:0] CNT_MAX         = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [INDEX_BITS-1:0] index;
        logic [TAG_W-1:0]      tag;
        logic [OFF_W-1:0]      offset;
        logic [63:0]           next_seq;
        logic [63:0]           target;
        logic                  not_taken;
        logic                  same_line;
    } t_btb_req;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [OFF_W-1:0] offset;
        logic [63:0]      target;
        logic [1:0]       counter;
    } t_btb_entry;

endpackage

// ----- rtl/core/btb_front.sv -----
// Branch target buffer front end: request decode and two-entry request queue.
module btb_front import btb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_next_seq,
    input  logic [63:0] i_branch_target,
    input  logic        i_not_taken,
    input  logic        i_clearing,
    output t_btb_req    o_req,
    output logic        o_req_valid,
    input  logic        i_req_pop
);

    t_btb_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wp;
    logic [QPTR_W-1:0]     r_rp;
    logic [QCNT_W-1:0]     r_cnt;
    logic [QCNT_W-1:0]     n_cnt;
    t_btb_req              dec;
    logic                  push;
    logic                  full;

    always_comb begin
        dec.cmd       = i_cmd;
        dec.index     = INDEX_BITS'(i_pc >> OFFSET_BITS);
        dec.tag       = TAG_W'(i_pc >> TAG_SHIFT);
        dec.offset    = OFF_W'(i_pc & OFF_MASK);
        dec.next_seq  = i_next_seq;
        dec.target    = i_branch_target;
        dec.not_taken = i_not_taken;
        dec.same_line = (INDEX_BITS'(i_branch_target >> OFFSET_BITS) == dec.index) &&
                        (TAG_W'(i_branch_target >> TAG_SHIFT) == dec.tag);
    end

    assign full        = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stall     = full || i_clearing;
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_req_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!push && i_req_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_req_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_pop |-> (r_cnt != '0))
        else $error("request queue popped while empty");
`endif

endmodule

// ----- rtl/core/btb_back.sv -----
// Branch target buffer back end: entry store, clear sweep, command execution, result register.
module btb_back import btb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_btb_req    i_req,
    input  logic        i_req_valid,
    output logic        o_req_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_next_pc,
    output logic        o_hit,
    output logic [31:0] o_eviction_total
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    t_btb_entry            r_mem [NUM_ENTRIES];
    t_btb_entry            r_rd;
    t_btb_req              r_item;
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic                  r_out_valid;
    logic [63:0]           r_out_npc;
    logic                  r_out_hit;
    logic [31:0]           r_evict;
    logic [31:0]           n_evict;

    logic                  out_free;
    logic                  tag_hit;
    logic                  full_hit;
    logic                  upd_we;
    t_btb_entry            upd_entry;
    logic [63:0]           res_npc;
    logic                  res_hit;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    t_btb_entry            mem_wdata;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_req_pop  = (r_state == S_IDLE) && i_req_valid;

    assign tag_hit  = r_rd.valid && (r_rd.tag == r_item.tag);
    assign full_hit = tag_hit && (r_rd.offset == r_item.offset);

    always_comb begin
        upd_we    = 1'b0;
        upd_entry = r_rd;
        res_npc   = '0;
        res_hit   = 1'b0;
        n_evict   = r_evict;
        unique case (r_item.cmd)
            CMD_PREDICT: begin
                res_hit = full_hit;
                res_npc = (full_hit && r_rd.counter[1]) ? r_rd.target : r_item.next_seq;
            end
            CMD_LOOKUP: begin
                res_hit = tag_hit;
                res_npc = tag_hit ? r_rd.target : '0;
            end
            CMD_TRAIN_TGT: begin
                upd_we          = 1'b1;
                upd_entry.valid = 1'b1;
                if (!r_item.same_line) begin
                    if (r_rd.target != r_item.target) begin
                        n_evict = r_evict + 32'd1;
                    end
                    upd_entry.target  = r_item.target;
                    upd_entry.tag     = r_item.tag;
                    upd_entry.offset  = r_item.offset;
                    upd_entry.counter = CNT_RESET_TAKEN;
                end
            end
            CMD_TRAIN_CNT: begin
                res_hit = full_hit;
                upd_we  = full_hit;
                if (r_item.not_taken) begin
                    if (r_rd.counter != '0) begin
                        upd_entry.counter = r_rd.counter - 2'd1;
                    end
                end else begin
                    if (r_rd.counter != CNT_MAX) begin
                        upd_entry.counter = r_rd.counter + 2'd1;
                    end
                end
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_item.index;
        mem_wdata = upd_entry;
        n_state   = r_state;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                if (&r_clr_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    mem_we  = upd_we;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_evict     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
            end
            if (r_state == S_LOOK && out_free) begin
                r_out_valid <= 1'b1;
                r_evict     <= n_evict;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_item <= i_req;
        end
        if (r_state == S_LOOK && out_free) begin
            r_out_npc <= res_npc;
            r_out_hit <= res_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_req_pop) begin
            r_rd <= r_mem[i_req.index];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_next_pc        = r_out_npc;
    assign o_hit            = r_out_hit;
    assign o_eviction_total = r_evict;

`ifndef SYNTHESIS
    a_look_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !out_free) |=> (r_state == S_LOOK))
        else $error("command left execute while result register was blocked");

    a_evict_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_evict != $past(r_evict))) |-> (r_evict == $past(r_evict) + 32'd1))
        else $error("eviction count moved by more than one");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result presented during clear sweep");
`endif

endmodule

// ----- rtl/core/branch_target_buffer.sv -----
// Branch target buffer top level: direct-mapped target store with 2-bit counters.
// Input channel: i_valid / o_stall with i_cmd, i_pc, i_next_seq, i_branch_target,
// i_not_taken. A transaction is taken on a rising edge with i_valid high and o_stall low.
// Commands: predict, look up target, train target, train counter.
// Output channel: o_valid / i_stall with o_next_pc, o_hit, o_eviction_total; one
// result transaction per input transaction, in order.
// Path: request queue, then entry read from the store, then execute, which updates the
// entry and loads the result register. Each transaction is read and then updated before
// the next one is read, so only one transaction is in the back end at a time.
// A two-entry request queue lets the input side keep accepting while a result waits.
// Reset: synchronous, active low. After reset the store is swept clear, one entry a
// cycle over all 2^INDEX_BITS entries (1024); o_stall stays high for the sweep.
// When i_stall holds the result, execution waits and the queue fills; once it is full
// o_stall rises until the result is taken.
module branch_target_buffer import btb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_next_seq,
    input  logic [63:0] i_branch_target,
    input  logic        i_not_taken,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_next_pc,
    output logic        o_hit,
    output logic [31:0] o_eviction_total
);

    t_btb_req req;
    logic     req_valid;
    logic     req_pop;
    logic     clearing;

    btb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_pc            (i_pc),
        .i_next_seq      (i_next_seq),
        .i_branch_target (i_branch_target),
        .i_not_taken     (i_not_taken),
        .i_clearing      (clearing),
        .o_req           (req),
        .o_req_valid     (req_valid),
        .i_req_pop       (req_pop)
    );

    btb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req),
        .i_req_valid      (req_valid),
        .o_req_pop        (req_pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_next_pc        (o_next_pc),
        .o_hit            (o_hit),
        .o_eviction_total (o_eviction_total)
    );

endmodule
